>>> hdl/assert_macros.svh
// Assertion shorthands shared by the RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge once reset has been released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/smcfd_pkg.sv
package smcfd_pkg;

  localparam int unsigned FrameLen  = 5;
  localparam int unsigned PosW      = 3;
  localparam int unsigned CfgAddrW  = 8;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned OutDataW  = 40;

  localparam logic [PosW-1:0] PosLast   = 3'(FrameLen - 1);
  localparam logic signed [7:0] RotLimit = 8'sd20;
  localparam logic [7:0] SpeedMax       = 8'd6;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] REG_MOTOR_CMD  = 8'd0;
  localparam logic [CfgAddrW-1:0] REG_SENSOR_CMD = 8'd1;
  localparam logic [CfgAddrW-1:0] REG_OK_REPLY   = 8'd2;
  localparam logic [CfgAddrW-1:0] REG_ERR_REPLY  = 8'd3;

  localparam logic [7:0] MotorCmdReset  = 8'd1;
  localparam logic [7:0] SensorCmdReset = 8'd2;
  localparam logic [7:0] OkReplyReset   = 8'd0;
  localparam logic [7:0] ErrReplyReset  = 8'd255;

  typedef struct packed {
    logic [7:0] motor_cmd;
    logic [7:0] sensor_cmd;
    logic [7:0] ok_reply;
    logic [7:0] err_reply;
  } cfg_t;

  // Frame as seen by the decoder when the next byte arrives
  typedef struct packed {
    logic       last;      // next byte is the checksum
    logic [7:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] spd;
    logic [7:0] xsum;
  } frame_t;

  typedef struct packed {
    logic              frame_done;
    logic [2:0]        speed_level;
    logic              speed_valid;
    logic signed [6:0] move_rotate;
    logic signed [5:0] move_sideways;
    logic signed [5:0] move_forward;
    logic              motion_valid;
    logic              frame_error;
    logic [7:0]        tx_byte;
  } result_t;

endpackage

>>> hdl/smcfd_collect.sv
module smcfd_collect (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  output smcfd_pkg::frame_t     frame,
  output logic [smcfd_pkg::PosW-1:0] pos
);
  import smcfd_pkg::*;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      xsum_r, xsum_nxt;
  logic [7:0]      bytes_r [4];
  logic            last;

  assign last = (pos_r == PosLast);

  always_comb begin
    pos_nxt  = pos_r;
    xsum_nxt = xsum_r;
    if (take) begin
      if (last) begin
        pos_nxt  = '0;
        xsum_nxt = '0;
      end else begin
        pos_nxt  = pos_r + 3'd1;
        xsum_nxt = xsum_r ^ rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      xsum_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      xsum_r <= xsum_nxt;
    end
  end

  // frame byte store: no reset, every slot is written before a decode
  always_ff @(posedge clk) begin
    if (take && !last) begin
      bytes_r[pos_r[1:0]] <= rx_byte;
    end
  end

  assign frame.last = last;
  assign frame.cmd  = bytes_r[0];
  assign frame.x    = bytes_r[1];
  assign frame.y    = bytes_r[2];
  assign frame.spd  = bytes_r[3];
  assign frame.xsum = xsum_r;
  assign pos        = pos_r;

endmodule

>>> hdl/smcfd_decode.sv
module smcfd_decode (
  input  smcfd_pkg::frame_t  frame,
  input  logic [7:0]         rx_byte,
  input  smcfd_pkg::cfg_t    cfg,
  output smcfd_pkg::result_t res
);
  import smcfd_pkg::*;

  logic              is_motor, is_sensor, sum_ok, err, motion;
  logic signed [7:0] ys;
  logic [7:0]        x_adj, y_adj;
  logic signed [5:0] x_q, y_q;
  logic              rot_en, spd_ok;

  // signed divide by four, truncated toward zero: bias negatives by three
  assign ys    = $signed(frame.y);
  assign x_adj = frame.x + {6'd0, frame.x[7], frame.x[7]};
  assign y_adj = frame.y + {6'd0, frame.y[7], frame.y[7]};
  assign x_q   = $signed(x_adj[7:2]);
  assign y_q   = $signed(y_adj[7:2]);

  assign is_motor  = (frame.cmd == cfg.motor_cmd);
  assign is_sensor = (frame.cmd == cfg.sensor_cmd);
  assign sum_ok    = (frame.xsum == rx_byte);
  assign rot_en    = (ys < RotLimit) && (ys > -RotLimit);
  assign spd_ok    = (frame.spd != 8'd0) && (frame.spd <= SpeedMax);

  // motor code wins when both codes match; a sensor frame ignores its checksum
  assign motion = frame.last && is_motor && sum_ok;
  assign err    = is_motor ? !sum_ok : !is_sensor;

  always_comb begin
    res = '0;
    if (frame.last) begin
      res.frame_done  = 1'b1;
      res.frame_error = err;
      res.tx_byte     = err ? cfg.err_reply : cfg.ok_reply;
    end
    if (motion) begin
      res.motion_valid  = 1'b1;
      res.move_forward  = y_q;
      res.move_sideways = x_q;
      res.move_rotate   = rot_en ? -{x_q[5], x_q} : 7'sd0;
      if (spd_ok) begin
        res.speed_valid = 1'b1;
        res.speed_level = frame.spd[2:0];
      end
    end
  end

endmodule

>>> hdl/spi_motor_command_frame_decoder.sv
// Reply: an accepted byte request's reply is registered and shows on the out_ channel in the next cycle.
// Throughput: one byte per cycle; the single output register is refilled in the
//   cycle it is drained, so in_tready only drops while a reply waits unclaimed.
// Reset: synchronous active-low rst_n clears the frame position, checksum, output
//   valid and restores the configuration registers to their defaults.
module spi_motor_command_frame_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [smcfd_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [smcfd_pkg::CfgDataW-1:0]    cfg_wdata,
  // received byte stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] rx_byte
  // reply stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] tx_byte, [8] frame_error, [9] motion_valid, [15:10] move_forward,
  // [21:16] move_sideways, [28:22] move_rotate, [29] speed_valid,
  // [32:30] speed_level, [39:33] zero
  output logic [smcfd_pkg::OutDataW-1:0]    out_tdata,
  output logic                              out_tlast  // frame_done
);
  import smcfd_pkg::*;

  `include "assert_macros.svh"

  cfg_t            cfg_r, cfg_nxt;
  frame_t          frame;
  logic [PosW-1:0] pos;
  result_t         res, res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            in_fire;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes to unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_MOTOR_CMD:  cfg_nxt.motor_cmd  = cfg_wdata;
        REG_SENSOR_CMD: cfg_nxt.sensor_cmd = cfg_wdata;
        REG_OK_REPLY:   cfg_nxt.ok_reply   = cfg_wdata;
        REG_ERR_REPLY:  cfg_nxt.err_reply  = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_cmd  <= MotorCmdReset;
      cfg_r.sensor_cmd <= SensorCmdReset;
      cfg_r.ok_reply   <= OkReplyReset;
      cfg_r.err_reply  <= ErrReplyReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: accept a new byte whenever the reply register is empty or
  // being drained in this same cycle.
  // ---------------------------------------------------------------------------
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Frame gathering: position, checksum and the four header bytes
  smcfd_collect u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_fire),
    .rx_byte (in_tdata),
    .frame   (frame),
    .pos     (pos)
  );

  // Decode straight off the stored frame and the incoming checksum byte
  smcfd_decode u_decode (
    .frame   (frame),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (res)
  );

  // ---------------------------------------------------------------------------
  // Reply register: load on accept, hold while stalled, clear valid on drain
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {7'd0,
                       res_r.speed_level,
                       res_r.speed_valid,
                       res_r.move_rotate,
                       res_r.move_sideways,
                       res_r.move_forward,
                       res_r.motion_valid,
                       res_r.frame_error,
                       res_r.tx_byte};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Position never runs past the checksum slot
  `ASSERT_CLK(a_pos_range, pos <= PosLast, "frame position out of range")
  // Completing a frame restarts the position
  `ASSERT_CLK(a_pos_wrap, (in_fire && frame.last) |=> (pos == '0), "position did not wrap")
  // Replies to mid-frame bytes carry nothing
  `ASSERT_CLK(a_mid_zero, (out_tvalid && !out_tlast) |-> (out_tdata == '0),
              "mid-frame reply not zero")
  // New motion only on an accepted completed frame
  `ASSERT_CLK(a_motion_ok, (out_tvalid && res_r.motion_valid) |->
              (out_tlast && !res_r.frame_error), "motion on rejected frame")

endmodule

>>> tb/sv/tb_spi_motor_command_frame_decoder.sv
module tb_spi_motor_command_frame_decoder;
  import smcfd_pkg::*;

  // Frame layout and decode limits
  localparam int FRAME_BYTES = 5;
  localparam int ROT_LIMIT   = 20;
  localparam int TOP_SPEED   = 6;
  localparam int REG_COUNT   = 4;   // indexes from here up are unused

  // Run shape
  localparam int PHASES         = 6;
  localparam int BYTES_PER_PASS = 230;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 200000;

  localparam result_t NO_REPLY = '0;

  // One row of the directed table: a received byte and, where it is obvious,
  // the reply it must give; other rows take the decoder model's answer.
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    result_t    want;
  } byte_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;     // [7:0] rx_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [7:0] tx_byte, [8] frame_error, [9] motion_valid, [15:10] move_forward,
  // [21:16] move_sideways, [28:22] move_rotate, [29] speed_valid,
  // [32:30] speed_level, [39:33] zero
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;         // frame_done

  // Decoder model state, advanced as each request is handed to the driver
  cfg_t       settings = cfg_t'({MotorCmdReset, SensorCmdReset, OkReplyReset, ErrReplyReset});
  logic [2:0] frame_pos = '0;
  logic [7:0] frame_buf [4];
  logic [7:0] frame_xor = '0;

  result_t   replies_due [$];
  byte_row_t directed_rows [$];
  int        errors_seen = 0;
  int        cycle_count = 0;
  int        in_gap_pct = 0;
  int        out_stall_pct = 0;

  spi_motor_command_frame_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abandon the run if the stream stalls for good
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Decode one received byte: gather the first four bytes of a frame and their
  // XOR, then judge the frame when its checksum byte arrives.
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t r;
    int      x;
    int      y;
    int      ay;
    logic    good;
    r = '0;
    if (frame_pos < 3'(FRAME_BYTES - 1)) begin
      frame_buf[frame_pos[1:0]] = b;
      frame_xor = frame_xor ^ b;
      frame_pos = frame_pos + 3'd1;
      return r;
    end
    // Motor wins when both command codes are equal
    if (frame_buf[0] == settings.motor_cmd) begin
      good = (frame_xor == b);
      if (good) begin
        x  = $signed(frame_buf[1]);
        y  = $signed(frame_buf[2]);
        ay = (y < 0) ? -y : y;
        r.motion_valid  = 1'b1;
        r.move_forward  = 6'(y / 4);
        r.move_sideways = 6'(x / 4);
        r.move_rotate   = (ay < ROT_LIMIT) ? 7'((-x) / 4) : 7'd0;
        if (frame_buf[3] >= 8'd1 && frame_buf[3] <= 8'(TOP_SPEED)) begin
          r.speed_valid = 1'b1;
          r.speed_level = frame_buf[3][2:0];
        end
      end
    end else if (frame_buf[0] == settings.sensor_cmd) begin
      // Sensor frames ignore the checksum byte
      good = 1'b1;
    end else begin
      good = 1'b0;
    end
    r.tx_byte     = good ? settings.ok_reply : settings.err_reply;
    r.frame_done  = 1'b1;
    r.frame_error = !good;
    frame_pos = '0;
    frame_xor = '0;
    return r;
  endfunction

  function automatic result_t frame_reply(input logic [7:0] tx, input logic err,
                                          input logic mv, input logic [5:0] fwd,
                                          input logic [5:0] side, input logic [6:0] rot,
                                          input logic sv, input logic [2:0] sl);
    result_t r;
    r = '0;
    r.tx_byte       = tx;
    r.frame_done    = 1'b1;
    r.frame_error   = err;
    r.motion_valid  = mv;
    r.move_forward  = fwd;
    r.move_sideways = side;
    r.move_rotate   = rot;
    r.speed_valid   = sv;
    r.speed_level   = sl;
    return r;
  endfunction

  function automatic byte_row_t row(input logic [7:0] rx, input bit typed = 1'b0,
                                    input result_t want = '0);
    byte_row_t r;
    r.rx    = rx;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_seen++;
    end
  endtask

  task automatic check_reply(input result_t want);
    compare_field("tx_byte", want.tx_byte, out_tdata[7:0]);
    compare_field("frame_done", want.frame_done, out_tlast);
    compare_field("frame_error", want.frame_error, out_tdata[8]);
    compare_field("motion_valid", want.motion_valid, out_tdata[9]);
    compare_field("move_forward", $signed(want.move_forward), $signed(out_tdata[15:10]));
    compare_field("move_sideways", $signed(want.move_sideways), $signed(out_tdata[21:16]));
    compare_field("move_rotate", $signed(want.move_rotate), $signed(out_tdata[28:22]));
    compare_field("speed_valid", want.speed_valid, out_tdata[29]);
    compare_field("speed_level", want.speed_level, out_tdata[32:30]);
    compare_field("tdata padding", 0, out_tdata[39:33]);
  endtask

  // Check each reply as it is taken, then decide whether to stall the next one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply taken with no request outstanding");
        errors_seen++;
      end else begin
        check_reply(replies_due.pop_front());
      end
    end
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Offer one byte, idling first at random; return at the edge that takes it.
  // tvalid is left high so that a following request keeps it up without a dip.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    predicted = decode_byte(b);
    replies_due.push_back(typed ? want : predicted);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop tvalid and hold until every request has been answered
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MOTOR_CMD:  settings.motor_cmd  = val;
      REG_SENSOR_CMD: settings.sensor_cmd = val;
      REG_OK_REPLY:   settings.ok_reply   = val;
      REG_ERR_REPLY:  settings.err_reply  = val;
      default: ;      // unused index: the block ignores it
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(REG_MOTOR_CMD, s.motor_cmd);
    write_reg(REG_SENSOR_CMD, s.sensor_cmd);
    write_reg(REG_OK_REPLY, s.ok_reply);
    write_reg(REG_ERR_REPLY, s.err_reply);
    write_reg(CfgAddrW'($urandom_range(REG_COUNT, 255)), 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest are stray bytes
  // that knock the framing out of step, bad checksums and unknown commands.
  task automatic stream_random(input int count);
    int         sent;
    int         pick;
    logic [7:0] fr [FRAME_BYTES];
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom));
          sent++;
        end
      end else begin
        // Pad out a broken frame so the next one lines up
        while (frame_pos != 0) begin
          send_byte(8'($urandom));
          sent++;
        end
        pick = $urandom_range(0, 99);
        fr[0] = (pick < 55) ? settings.motor_cmd :
                (pick < 75) ? settings.sensor_cmd : 8'($urandom);
        fr[1] = 8'($urandom);
        // Keep Y near the rotation cut-off half of the time
        fr[2] = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 48) - 24);
        fr[3] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        fr[4] = fr[0] ^ fr[1] ^ fr[2] ^ fr[3];
        if ($urandom_range(0, 99) < 20) fr[4] = fr[4] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < FRAME_BYTES; k++) send_byte(fr[k]);
        sent += FRAME_BYTES;
      end
    end
  endtask

  initial begin
    cfg_t s;
    logic [7:0] same;

    // Directed frames under the reset settings.
    // Motor frame at the X extreme with Y zero and top speed: motion, sideways, rotate and speed lit.
    directed_rows.push_back(row(8'h01, 1'b1, NO_REPLY));
    directed_rows.push_back(row(8'h80, 1'b1, NO_REPLY));
    directed_rows.push_back(row(8'h00, 1'b1, NO_REPLY));
    directed_rows.push_back(row(8'h06, 1'b1, NO_REPLY));
    // sideways -32, rotate +32
    directed_rows.push_back(row(8'h87, 1'b1,
      frame_reply(OkReplyReset, 1'b0, 1'b1, 6'h00, 6'h20, 7'h20, 1'b1, 3'd6)));
    // Motor frame at X top, Y at the rotation limit (rotation off), speed zero
    directed_rows.push_back(row(8'h01));
    directed_rows.push_back(row(8'h7F));
    directed_rows.push_back(row(8'hEC));
    directed_rows.push_back(row(8'h00));
    directed_rows.push_back(row(8'h92));
    // Motor frame with a bad checksum: rejected
    directed_rows.push_back(row(8'h01));
    directed_rows.push_back(row(8'h10));
    directed_rows.push_back(row(8'h20));
    directed_rows.push_back(row(8'h03));
    directed_rows.push_back(row(8'h33, 1'b1,
      frame_reply(ErrReplyReset, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0)));
    // Sensor frame with a junk checksum: still accepted
    directed_rows.push_back(row(8'h02));
    directed_rows.push_back(row(8'hFF));
    directed_rows.push_back(row(8'hFF));
    directed_rows.push_back(row(8'hFF));
    directed_rows.push_back(row(8'hAA, 1'b1,
      frame_reply(OkReplyReset, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0)));
    // Unknown command with a good checksum: rejected
    directed_rows.push_back(row(8'hFF));
    directed_rows.push_back(row(8'h00));
    directed_rows.push_back(row(8'h00));
    directed_rows.push_back(row(8'h00));
    directed_rows.push_back(row(8'hFF, 1'b1,
      frame_reply(ErrReplyReset, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      // Receiver-heavy idling, then sender-heavy, then none at all
      case (ph / 2)
        0: begin in_gap_pct = 24; out_stall_pct = 45; end
        1: begin in_gap_pct = 45; out_stall_pct = 24; end
        default: begin in_gap_pct = 0; out_stall_pct = 0; end
      endcase
      if (ph == 0) begin
        foreach (directed_rows[i])
          send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
      end else begin
        settle();
        same = 8'($urandom);
        case (ph)
          1: s = cfg_t'({8'h00, 8'hFF, 8'hFF, 8'h00});
          2: s = cfg_t'({8'hFF, 8'h00, 8'h00, 8'hFF});
          3: s = cfg_t'({same, same, 8'($urandom), 8'($urandom)});   // codes collide
          default: s = cfg_t'($urandom);
        endcase
        load_settings(s);
      end
      stream_random(BYTES_PER_PASS);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors_seen == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/smcfd_pkg.sv
hdl/smcfd_collect.sv
hdl/smcfd_decode.sv
hdl/spi_motor_command_frame_decoder.sv
tb/sv/tb_spi_motor_command_frame_decoder.sv
